// ===== rtl/hrc_pkg.sv =====
// shared constants, types and direction tables for the hex ring coordinate converter
`default_nettype none

package hrc_pkg;

	localparam int MAX_RING       = 15;
	localparam int RING_FIELD_MAX = 15;

	localparam int RING_W     = 4;
	localparam int POS_W      = 7;
	localparam int LAT_W      = 5;
	localparam int DATA_W     = 24;
	localparam int RING_CMP_W = 7;
	// signed width of the lattice-to-ring intermediates
	localparam int AB_W       = 7;
	localparam int POS_CALC_W = 10;

	localparam int RING_LSB = 0;
	localparam int POS_LSB  = RING_LSB + RING_W;
	localparam int X_LSB    = POS_LSB + POS_W;
	localparam int Y_LSB    = X_LSB + LAT_W;
	localparam int FIELDS_W = Y_LSB + LAT_W;

	typedef enum logic {
		ACT_TO_LATTICE = 1'b0,
		ACT_TO_RING    = 1'b1
	} action_t;

	typedef logic [2:0]        sext_t;
	typedef logic signed [1:0] dir_t;

	localparam sext_t SEXT_0 = 3'd0;
	localparam sext_t SEXT_1 = 3'd1;
	localparam sext_t SEXT_2 = 3'd2;
	localparam sext_t SEXT_3 = 3'd3;
	localparam sext_t SEXT_4 = 3'd4;
	localparam sext_t SEXT_5 = 3'd5;

	// unit directions in corner order
	localparam dir_t DIR_X [6] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};
	localparam dir_t DIR_Y [6] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd0};
	// direction two steps on from each corner
	localparam sext_t SIDE_DIR [6] = '{SEXT_2, SEXT_3, SEXT_4, SEXT_5, SEXT_0, SEXT_1};

	function automatic logic signed [AB_W-1:0] scale_dir(logic signed [AB_W-1:0] v, dir_t d);
		if (d == 2'sd1) begin
			return v;
		end else if (d == -2'sd1) begin
			return -v;
		end else begin
			return '0;
		end
	endfunction

	function automatic sext_t pick_sextant(logic signed [LAT_W-1:0] x, logic signed [LAT_W-1:0] y);
		if (x >= 0) begin
			if (y > 0) begin
				return (x < y) ? SEXT_0 : SEXT_1;
			end
			return SEXT_2;
		end
		if (y >= 0) begin
			return SEXT_5;
		end
		return (x > y) ? SEXT_3 : SEXT_4;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hex_ring_coordinate_converter_top.sv =====
// top level: three-stage pipelined hex ring / lattice coordinate converter
//
// input channel s_*: s_tuser selects the conversion (0 ring/position to lattice,
// 1 lattice to ring/position), s_tdata carries ring, position, lattice x and y.
// output channel m_*: m_tdata carries ring, position, lattice x and y of the
// result, m_tuser is the error flag; on error every data field is zero.
// one result item per input item, in order.
// an accepted item passes through three register stages (decode, corner compare,
// lattice assembly), the accepting one included, before it shows on m_tvalid.
// throughput: one item per cycle while m_tready stays high; each stage holds one item and a stage
// loads whenever it is empty or its successor moves on.
// when the receiver drops m_tready the pipeline fills up behind the output
// register and s_tready goes low only once all three stages hold an item.
// reset clears the stage valid bits only; the pipeline comes up empty.
`default_nettype none

module hex_ring_coordinate_converter_top
	import hrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// ring_in[3:0], position_in[10:4], lattice_x_in[15:11], lattice_y_in[20:16]
	input  wire logic [DATA_W-1:0] s_tdata,
	// action
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// ring_out[3:0], position_out[10:4], lattice_x_out[15:11], lattice_y_out[20:16]
	output logic [DATA_W-1:0]      m_tdata,
	// error
	output logic                   m_tuser
);

	logic rdy1, rdy2, rdy3;
	logic v_s1, v_s2, v_s3;

	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s3;

	// stage 1: decode, range checks, sextant and projections

	logic [RING_W-1:0]            r_in;
	logic [POS_W-1:0]             p_in;
	logic signed [LAT_W-1:0]      x_in, y_in;
	logic [POS_W-1:0]             six_r;
	logic                         origin_in, err0_in;
	sext_t                        sext_in, sd_in;
	logic signed [AB_W-1:0]       xe, ye, det_a, det_b, a_in, b_in;

	assign r_in = s_tdata[POS_LSB-1:RING_LSB];
	assign p_in = s_tdata[X_LSB-1:POS_LSB];
	assign x_in = s_tdata[Y_LSB-1:X_LSB];
	assign y_in = s_tdata[FIELDS_W-1:Y_LSB];
	assign xe   = {{(AB_W-LAT_W){x_in[LAT_W-1]}}, x_in};
	assign ye   = {{(AB_W-LAT_W){y_in[LAT_W-1]}}, y_in};

	always_comb begin
		six_r     = ({3'b000, r_in} << 2) + ({3'b000, r_in} << 1);
		origin_in = (r_in == '0) && (p_in == '0);
		err0_in   = (r_in == '0) || (p_in >= six_r)
			|| ({3'b000, r_in} > RING_CMP_W'(MAX_RING))
			|| ({3'b000, r_in} > RING_CMP_W'(RING_FIELD_MAX));
		sext_in   = pick_sextant(x_in, y_in);
		sd_in     = SIDE_DIR[sext_in];
		// determinants are always plus or minus one
		det_a = scale_dir(AB_W'(DIR_Y[sext_in]), DIR_X[sd_in])
			- scale_dir(AB_W'(DIR_X[sext_in]), DIR_Y[sd_in]);
		det_b = scale_dir(AB_W'(DIR_Y[sd_in]), DIR_X[sext_in])
			- scale_dir(AB_W'(DIR_X[sd_in]), DIR_Y[sext_in]);
		a_in = scale_dir(scale_dir(ye, DIR_X[sd_in]) - scale_dir(xe, DIR_Y[sd_in]),
			dir_t'(det_a[1:0]));
		b_in = scale_dir(scale_dir(ye, DIR_X[sext_in]) - scale_dir(xe, DIR_Y[sext_in]),
			dir_t'(det_b[1:0]));
	end

	action_t                act_s1;
	logic [RING_W-1:0]      r_s1;
	logic [POS_W-1:0]       p_s1;
	logic                   origin_s1, err0_s1;
	sext_t                  sext_s1;
	logic signed [AB_W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			act_s1    <= action_t'(s_tuser);
			r_s1      <= r_in;
			p_s1      <= p_in;
			origin_s1 <= origin_in;
			err0_s1   <= err0_in;
			sext_s1   <= sext_in;
			a_s1      <= a_in;
			b_s1      <= b_in;
		end
	end

	// stage 2: corner by compare against ring multiples, position from projections

	sext_t                        corner;
	logic [POS_W-1:0]             mult, base;
	logic [RING_W-1:0]            offset;
	logic signed [POS_CALC_W-1:0] a_ext, b_ext, pos, six_a;
	logic                         err1;

	always_comb begin
		corner = SEXT_0;
		base   = '0;
		mult   = '0;
		for (int k = 1; k < 6; k++) begin
			mult = POS_W'(k) * {3'b000, r_s1};
			if (p_s1 >= mult) begin
				corner = sext_t'(k);
				base   = mult;
			end
		end
		offset = RING_W'(p_s1 - base);

		a_ext = {{(POS_CALC_W-AB_W){a_s1[AB_W-1]}}, a_s1};
		b_ext = {{(POS_CALC_W-AB_W){b_s1[AB_W-1]}}, b_s1};
		pos   = $signed({{(POS_CALC_W-3){1'b0}}, sext_s1}) * a_ext + b_ext;
		six_a = (a_ext <<< 2) + (a_ext <<< 1);
		err1  = (a_s1 < 0)
			|| (a_s1 > AB_W'(MAX_RING)) || (a_s1 > AB_W'(RING_FIELD_MAX))
			|| (pos < 0)
			|| ((a_s1 == '0) && (pos != '0))
			|| ((a_s1 > 0) && (pos >= six_a));
	end

	action_t           act_s2;
	logic [RING_W-1:0] r_s2, offset_s2, ring_res_s2;
	logic [POS_W-1:0]  pos_res_s2;
	sext_t             corner_s2;
	logic              origin_s2, err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			act_s2      <= act_s1;
			r_s2        <= r_s1;
			offset_s2   <= offset;
			corner_s2   <= corner;
			origin_s2   <= (act_s1 == ACT_TO_LATTICE) && origin_s1;
			err_s2      <= (act_s1 == ACT_TO_LATTICE) ? (err0_s1 && !origin_s1) : err1;
			ring_res_s2 <= a_s1[RING_W-1:0];
			pos_res_s2  <= pos[POS_W-1:0];
		end
	end

	// stage 3: lattice point from corner direction and side direction

	sext_t                  side;
	logic signed [AB_W-1:0] r_ext, m_ext, lat_x, lat_y;
	logic [DATA_W-1:0]      data_nx;

	always_comb begin
		side  = SIDE_DIR[corner_s2];
		r_ext = AB_W'({3'b000, r_s2});
		m_ext = AB_W'({3'b000, offset_s2});
		lat_x = scale_dir(r_ext, DIR_X[corner_s2]) + scale_dir(m_ext, DIR_X[side]);
		lat_y = scale_dir(r_ext, DIR_Y[corner_s2]) + scale_dir(m_ext, DIR_Y[side]);
		data_nx = '0;
		if (err_s2 || origin_s2) begin
			data_nx = '0;
		end else if (act_s2 == ACT_TO_LATTICE) begin
			data_nx[Y_LSB-1:X_LSB]    = lat_x[LAT_W-1:0];
			data_nx[FIELDS_W-1:Y_LSB] = lat_y[LAT_W-1:0];
		end else begin
			data_nx[POS_LSB-1:RING_LSB] = ring_res_s2;
			data_nx[X_LSB-1:POS_LSB]    = pos_res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			m_tdata <= data_nx;
			m_tuser <= err_s2;
		end
	end

endmodule

`default_nettype wire

// ===== dv/hex_ring_coordinate_converter_top_tb.sv =====
// self-checking testbench for the hex ring / lattice coordinate converter
`default_nettype none

module hex_ring_coordinate_converter_top_tb;
	import hrc_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 12;
	localparam int ITEMS_PER_PH = 617;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_DIRECTED   = 25;

	// unit directions in corner order
	localparam int HEX_DX [6] = '{0, 1, 1, 0, -1, -1};
	localparam int HEX_DY [6] = '{1, 1, 0, -1, -1, 0};

	typedef struct packed {
		action_t                  act;
		logic [RING_W-1:0]        ring;
		logic [POS_W-1:0]         pos;
		logic signed [LAT_W-1:0]  lx;
		logic signed [LAT_W-1:0]  ly;
	} conv_req_t;

	typedef struct packed {
		logic [RING_W-1:0]        ring;
		logic [POS_W-1:0]         pos;
		logic signed [LAT_W-1:0]  lx;
		logic signed [LAT_W-1:0]  ly;
		logic                     err;
	} conv_res_t;

	// fixed = 1: expected result typed in; otherwise taken from the predictor
	typedef struct packed {
		action_t act;
		int      ring;
		int      pos;
		int      x;
		int      y;
		bit      fixed;
		int      e_ring;
		int      e_pos;
		int      e_x;
		int      e_y;
		bit      e_err;
	} stim_row_t;

	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// origin both ways
		'{ACT_TO_LATTICE, 0,   0,   0,   0, 1'b1, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0,   0,   0, 1'b1, 0, 0, 0,  0, 1'b0},
		// zero ring with a nonzero position
		'{ACT_TO_LATTICE, 0,   5,   0,   0, 1'b1, 0, 0, 0,  0, 1'b1},
		'{ACT_TO_LATTICE, 0, 127, -16,  15, 1'b1, 0, 0, 0,  0, 1'b1},
		// position past the end of the ring
		'{ACT_TO_LATTICE, 1,   6,   0,   0, 1'b1, 0, 0, 0,  0, 1'b1},
		'{ACT_TO_LATTICE, 15, 90,   0,   0, 1'b1, 0, 0, 0,  0, 1'b1},
		'{ACT_TO_LATTICE, 15, 127,  0,   0, 1'b1, 0, 0, 0,  0, 1'b1},
		// corner zero points straight up
		'{ACT_TO_LATTICE, 1,   0,   0,   0, 1'b1, 0, 0, 0,  1, 1'b0},
		'{ACT_TO_LATTICE, 15,  0,   0,   0, 1'b1, 0, 0, 0, 15, 1'b0},
		'{ACT_TO_LATTICE, 15, 89,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		// every corner of ring 3, with offsets
		'{ACT_TO_LATTICE, 3,   1,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_LATTICE, 3,   5,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_LATTICE, 3,   7,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_LATTICE, 3,  10,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_LATTICE, 3,  14,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_LATTICE, 3,  17,   0,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		// unused lattice fields set, must be ignored
		'{ACT_TO_LATTICE, 2,   3,  -1,  -1, 1'b0, 0, 0, 0,  0, 1'b0},
		// -16 on the axis lands on ring 16
		'{ACT_TO_RING,    15, 127, -16,  0, 1'b1, 0, 0, 0,  0, 1'b1},
		'{ACT_TO_RING,    0,   0,  15,  15, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0, -16, -16, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0,  15, -15, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0, -15,  15, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0,   1,   0, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0,  -1,  -1, 1'b0, 0, 0, 0,  0, 1'b0},
		'{ACT_TO_RING,    0,   0,   0,  -7, 1'b0, 0, 0, 0,  0, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tuser;

	conv_res_t pending_results [$];
	int        mismatches = 0;
	int        tx_gap_pct = 0;
	int        rx_gap_pct = 0;
	bit        hold_req = 1'b0;
	int        cycles = 0;

	hex_ring_coordinate_converter_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic conv_res_t ring_lattice_predict(conv_req_t q);
		conv_res_t o;
		int r, p, corner, offset, side, x, y, s, c0, c1, s0, s1, det, a, b, ps;
		o = '0;
		if (q.act == ACT_TO_LATTICE) begin
			r = int'(q.ring);
			p = int'(q.pos);
			if (r == 0 && p == 0) begin
				return o;
			end
			if (r == 0 || p >= 6 * r || r > MAX_RING || r > RING_FIELD_MAX) begin
				o.err = 1'b1;
				return o;
			end
			corner = p / r;
			offset = p % r;
			side = (corner + 2) % 6;
			o.lx = LAT_W'(r * HEX_DX[corner] + offset * HEX_DX[side]);
			o.ly = LAT_W'(r * HEX_DY[corner] + offset * HEX_DY[side]);
		end else begin
			x = int'(q.lx);
			y = int'(q.ly);
			if (x >= 0) begin
				s = (y > 0) ? ((x < y) ? 0 : 1) : 2;
			end else if (y >= 0) begin
				s = 5;
			end else begin
				s = (x > y) ? 3 : 4;
			end
			side = (s + 2) % 6;
			c0 = HEX_DX[s];
			c1 = HEX_DY[s];
			s0 = HEX_DX[side];
			s1 = HEX_DY[side];
			// determinant is +1 or -1, so it is its own inverse
			det = c1 * s0 - c0 * s1;
			a = (y * s0 - x * s1) * det;
			b = (y * c0 - x * c1) * -det;
			if (a < 0 || a > MAX_RING || a > RING_FIELD_MAX) begin
				o.err = 1'b1;
				return o;
			end
			ps = s * a + b;
			if (ps < 0 || (a == 0 && ps != 0) || (a > 0 && ps >= 6 * a)) begin
				o.err = 1'b1;
				return o;
			end
			o.ring = RING_W'(a);
			o.pos = POS_W'(ps);
		end
		return o;
	endfunction

	function automatic conv_req_t random_request();
		conv_req_t q;
		int pick, r;
		pick = $urandom_range(0, 99);
		q.lx = LAT_W'($urandom);
		q.ly = LAT_W'($urandom);
		q.ring = RING_W'($urandom);
		q.pos = POS_W'($urandom);
		if (pick < 40) begin
			// well-formed ring/position
			r = $urandom_range(1, 15);
			q.act = ACT_TO_LATTICE;
			q.ring = RING_W'(r);
			q.pos = POS_W'($urandom_range(0, 6 * r - 1));
		end else if (pick < 50) begin
			q.act = ACT_TO_LATTICE;
		end else begin
			q.act = ACT_TO_RING;
		end
		return q;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input conv_req_t q, input conv_res_t exp_res);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= q.act;
		s_tdata <= {{(DATA_W - FIELDS_W){1'b0}}, q.ly, q.lx, q.pos, q.ring};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pending_results.insert(pending_results.size(), exp_res);
		@(negedge clk);
	endtask

	task automatic compare_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// receiver: ready decided at the rising edge, driven at the falling edge
	initial begin
		int  hold_left;
		bit  ready_nxt;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_nxt = 1'b0;
			end else begin
				ready_nxt = ($urandom_range(0, 99) >= rx_gap_pct);
			end
			@(negedge clk);
			m_tready <= ready_nxt;
		end
	end

	// result checker
	initial begin
		conv_res_t exp_res;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing pending: tdata %h tuser %b",
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					exp_res = pending_results.pop_front();
					compare_field("ring_out", int'(exp_res.ring),
						int'(m_tdata[RING_LSB +: RING_W]));
					compare_field("position_out", int'(exp_res.pos),
						int'(m_tdata[POS_LSB +: POS_W]));
					compare_field("lattice_x_out", int'(exp_res.lx),
						int'($signed(m_tdata[X_LSB +: LAT_W])));
					compare_field("lattice_y_out", int'(exp_res.ly),
						int'($signed(m_tdata[Y_LSB +: LAT_W])));
					compare_field("error", int'(exp_res.err), int'(m_tuser));
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		conv_req_t q;
		conv_res_t exp_res;
		stim_row_t row;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_gap_pct = 20;
		rx_gap_pct = 69;
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			q.act = row.act;
			q.ring = RING_W'(row.ring);
			q.pos = POS_W'(row.pos);
			q.lx = LAT_W'(row.x);
			q.ly = LAT_W'(row.y);
			if (row.fixed) begin
				exp_res.ring = RING_W'(row.e_ring);
				exp_res.pos = POS_W'(row.e_pos);
				exp_res.lx = LAT_W'(row.e_x);
				exp_res.ly = LAT_W'(row.e_y);
				exp_res.err = row.e_err;
			end else begin
				exp_res = ring_lattice_predict(q);
			end
			send_item(q, exp_res);
		end

		for (int ph = 0; ph < 3; ph++) begin
			tx_gap_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
			rx_gap_pct = (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
			// back-pressure burst while the sender streams without gaps
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PH; n++) begin
				q = random_request();
				send_item(q, ring_lattice_predict(q));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/hrc_pkg.sv
rtl/hex_ring_coordinate_converter_top.sv
dv/hex_ring_coordinate_converter_top_tb.sv
